[hdl/tlaik_pkg.sv]
// Shared constants, codes and the arctangent table for the two-link arm IK core.
`timescale 1ns / 1ps
package tlaik_pkg;

  localparam int unsigned CordicSteps   = 16;
  localparam int unsigned AngleFracBits = 12;
  localparam int unsigned AtanLen       = 24;

  localparam int unsigned LenW    = 14;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned NumW    = 33;
  localparam int unsigned DenW    = 35;
  localparam int unsigned QuoBits = 29;
  localparam int unsigned CosW    = 25;
  localparam int unsigned AngW    = 32;
  localparam int unsigned OneQ24  = 16777216;

  localparam logic [LenW-1:0] LinkReset = 14'd4000;
  localparam logic [31:0]     PiQ30     = 32'd3373259426;
  localparam logic [31:0]     HalfPiQ30 = 32'd1686629713;

  typedef enum logic [1:0] {
    CFG_LINK_A = 2'd0,
    CFG_LINK_B = 2'd1
  } cfg_idx_e;

  function automatic logic [30:0] atan_q30(int unsigned i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314857;
      1:  v = 31'd497837830;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/two_link_arm_inverse_kinematics_core.sv]
// Top level of the two-link planar arm inverse kinematics core.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+----------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tdata: target_x, target_y
//  m_axis    | out       | m_axis_tvalid/tready   | tdata: shoulder_angle, elbow_angle
//            |           |                        | tuser: out_of_reach, at_origin, below_limit
//  cfg       | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (link lengths)
//
// One point enters per cycle unless the pipeline stalls; the path runs through the radius
// square root (20 stages), the bit-serial divider (29 stages), the cosine square root
// (25 stages) and two CORDIC chains of CORDIC_STEPS stages each in series.
// Reset clears all valid bits and loads both link lengths with 4000.
// The whole pipeline advances when the output register is empty or being taken;
// otherwise every stage holds, and s_axis_tready is low.
`timescale 1ns / 1ps
module two_link_arm_inverse_kinematics_core #(
  parameter int unsigned CORDIC_STEPS    = tlaik_pkg::CordicSteps,
  parameter int unsigned ANGLE_FRAC_BITS = tlaik_pkg::AngleFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [15:0] target_x, [31:16] target_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [15:0] shoulder_angle, [29:16] elbow_angle, [31:30] 0
  output logic [2:0]  m_axis_tuser,    // [0] out_of_reach, [1] at_origin, [2] below_limit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  localparam int unsigned LW  = tlaik_pkg::LenW;
  localparam int unsigned XW  = tlaik_pkg::CoordW;
  localparam int unsigned RN  = 20;
  localparam int unsigned RVW = 2 * RN;
  localparam int unsigned SH  = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned PW  = 42;

  localparam logic signed [34:0] Pi    = $signed({3'b000, tlaik_pkg::PiQ30});
  localparam logic signed [34:0] Rnd   = 35'sd1 <<< (SH - 1);
  localparam logic signed [34:0] SoMax = 35'sd32767;
  localparam logic signed [34:0] SoMin = -35'sd32768;
  localparam logic signed [34:0] EoMax = 35'sd16383;

  typedef struct packed {
    logic signed [32:0] numb;
    logic signed [32:0] numl;
    logic [28:0]        denb;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic               origin;
  } rside_t;

  typedef struct packed {
    logic [31:0] bang;
    logic        bclamp;
    logic [31:0] lang;
    logic        lclamp;
    logic        origin;
    logic        xneg;
    logic        yneg;
  } pside_t;

  logic en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // link registers
  logic [LW-1:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= tlaik_pkg::LinkReset;
      b_q <= tlaik_pkg::LinkReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tlaik_pkg::CFG_LINK_A: a_q <= cfg_data_i;
        tlaik_pkg::CFG_LINK_B: b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                 v0_q;
  logic signed [XW-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= s_axis_tdata[15:0];
      y0_q <= s_axis_tdata[31:16];
    end
  end

  // squares
  logic                 v1_q;
  logic signed [XW-1:0] x1_q, y1_q;
  logic [30:0]          xx_q, yy_q;
  logic [27:0]          aa_q, bb_q, ab_q;
  logic signed [31:0]   xx_d, yy_d;

  always_comb begin
    xx_d = x0_q * x0_q;
    yy_d = y0_q * y0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= x0_q;
      y1_q <= y0_q;
      xx_q <= xx_d[30:0];
      yy_q <= yy_d[30:0];
      aa_q <= a_q * a_q;
      bb_q <= b_q * b_q;
      ab_q <= a_q * b_q;
    end
  end

  // sums and radius square root
  logic         rv_q    [RN+1];
  logic [RVW-1:0] rrad_q [RN+1];
  logic [RN+1:0] rrem_q [RN+1];
  logic [RN-1:0] rroot_q [RN+1];
  rside_t       rside_q [RN+1];

  logic [31:0] rr;
  rside_t      rs_d;

  always_comb begin
    rr          = {1'b0, xx_q} + {1'b0, yy_q};
    rs_d.numb   = $signed({5'b0, aa_q}) + $signed({5'b0, bb_q}) - $signed({1'b0, rr});
    rs_d.numl   = $signed({5'b0, aa_q}) - $signed({5'b0, bb_q}) + $signed({1'b0, rr});
    rs_d.denb   = {ab_q, 1'b0};
    rs_d.x      = x1_q;
    rs_d.y      = y1_q;
    rs_d.origin = (rr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else if (en) begin
      rv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rrad_q[0]  <= {rr, 8'b0};
      rrem_q[0]  <= '0;
      rroot_q[0] <= '0;
      rside_q[0] <= rs_d;
    end
  end

  for (genvar j = 0; j < RN; j++) begin : g_rsqrt
    logic [RN+1:0] r2, t;
    logic          ge;

    always_comb begin
      r2 = {rrem_q[j][RN-1:0], rrad_q[j][RVW-1-2*j -: 2]};
      t  = {rroot_q[j], 2'b01};
      ge = r2 >= t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[j+1] <= 1'b0;
      end else if (en) begin
        rv_q[j+1] <= rv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rrad_q[j+1]  <= rrad_q[j];
        rrem_q[j+1]  <= ge ? (r2 - t) : r2;
        rroot_q[j+1] <= {rroot_q[j][RN-2:0], ge};
        rside_q[j+1] <= rside_q[j];
      end
    end
  end

  // shoulder denominator
  logic        v3_q;
  rside_t      s3_q;
  logic [34:0] denl_q;
  logic [33:0] ar;

  always_comb begin
    ar = a_q * rroot_q[RN];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= rv_q[RN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= rside_q[RN];
      denl_q <= {ar, 1'b0};
    end
  end

  // both arc cosines
  logic        bv, lv, bclamp, lclamp, lorigin;
  logic [31:0] bang, lang;
  logic [31:0] bxy;

  tlaik_acos #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (2 * XW)
  ) u_acos_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (s3_q.numb),
    .den_i   ({2'b00, s3_q.denb, 4'b0}),
    .side_i  ({s3_q.y, s3_q.x}),
    .valid_o (bv),
    .angle_o (bang),
    .clamp_o (bclamp),
    .side_o  (bxy)
  );

  tlaik_acos #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (1)
  ) u_acos_shoulder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (s3_q.numl),
    .den_i   (denl_q),
    .side_i  (s3_q.origin),
    .valid_o (lv),
    .angle_o (lang),
    .clamp_o (lclamp),
    .side_o  (lorigin)
  );

  // polar angle
  logic [XW-1:0] absx, absy;
  pside_t        ps_d, ps_q;
  logic          pv;
  logic [31:0]   pang;

  always_comb begin
    absx        = bxy[XW-1] ? XW'(-$signed(bxy[XW-1:0])) : bxy[XW-1:0];
    absy        = bxy[2*XW-1] ? XW'(-$signed(bxy[2*XW-1:XW])) : bxy[2*XW-1:XW];
    ps_d.bang   = bang;
    ps_d.bclamp = bclamp;
    ps_d.lang   = lang;
    ps_d.lclamp = lclamp;
    ps_d.origin = lorigin;
    ps_d.xneg   = bxy[XW-1];
    ps_d.yneg   = bxy[2*XW-1];
  end

  tlaik_cordic #(
    .W      (PW),
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(pside_t))
  ) u_polar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bv && lv),
    .px_i    ($signed({2'b00, absx, 24'b0})),
    .py_i    ($signed({2'b00, absy, 24'b0})),
    .side_i  (ps_d),
    .valid_o (pv),
    .angle_o (pang),
    .side_o  (ps_q)
  );

  // final angles
  logic signed [34:0] th, eef, alpha, bt, so_w, eo_w;
  logic [15:0]        so;
  logic [13:0]        eo;
  logic               below;
  logic [31:0]        data_d, data_q;
  logic [2:0]         user_d, user_q;
  logic               out_v_q;

  always_comb begin
    th = $signed({3'b000, pang});
    if (!ps_q.xneg && !ps_q.yneg) begin
      eef = th;
    end else if (ps_q.xneg && !ps_q.yneg) begin
      eef = Pi - th;
    end else if (ps_q.xneg) begin
      eef = Pi + th;
    end else begin
      eef = (Pi <<< 1) - th;
    end
    alpha = eef - $signed({3'b000, ps_q.lang});
    below = alpha < -Pi;
    bt    = Pi - $signed({3'b000, ps_q.bang});
    so_w  = (alpha + Rnd) >>> SH;
    eo_w  = (bt + Rnd) >>> SH;
    if (so_w > SoMax) begin
      so = SoMax[15:0];
    end else if (so_w < SoMin) begin
      so = SoMin[15:0];
    end else begin
      so = so_w[15:0];
    end
    if (eo_w > EoMax) begin
      eo = EoMax[13:0];
    end else if (eo_w < 0) begin
      eo = '0;
    end else begin
      eo = eo_w[13:0];
    end
    if (ps_q.origin) begin
      data_d = '0;
      user_d = 3'b010;
    end else begin
      data_d = {2'b00, eo, so};
      user_d = {below, 1'b0, ps_q.bclamp || ps_q.lclamp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0]
      && !m_axis_tuser[2])
    else $error("origin result carries nonzero angles or flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v0_q) && $stable(v3_q) && $stable(out_v_q))
    else $error("pipeline moved during stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bv != lv) |-> 1'b0)
    else $error("arc cosine lanes out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:30] == 2'b00))
    else $error("tdata padding not zero");

endmodule

[hdl/tlaik_cordic.sv]
// Pipelined first-quadrant vectoring CORDIC, one rotation per stage, Q30 angle out.
`timescale 1ns / 1ps
module tlaik_cordic #(
  parameter int unsigned W      = 42,
  parameter int unsigned STEPS  = tlaik_pkg::CordicSteps,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [W-1:0]           px_i,
  input  logic signed [W-1:0]           py_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [tlaik_pkg::AngW-1:0]    angle_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam logic signed [32:0] HalfPi = $signed({1'b0, tlaik_pkg::HalfPiQ30});

  logic                v_q    [STEPS+1];
  logic signed [W-1:0] x_q    [STEPS+1];
  logic signed [W-1:0] y_q    [STEPS+1];
  logic signed [32:0]  z_q    [STEPS+1];
  logic [SIDE_W-1:0]   side_q [STEPS+1];

  logic                        out_v_q;
  logic [tlaik_pkg::AngW-1:0]  ang_q, ang_d;
  logic [SIDE_W-1:0]           out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= px_i;
      y_q[0]    <= py_i;
      z_q[0]    <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [32:0] Atan = $signed({2'b00, tlaik_pkg::atan_q30(i)});
    logic signed [W-1:0] xs, ys, xn_d, yn_d;
    logic signed [32:0]  zn_d;

    always_comb begin
      xs   = x_q[i] >>> i;
      ys   = y_q[i] >>> i;
      xn_d = x_q[i];
      yn_d = y_q[i];
      zn_d = z_q[i];
      if (y_q[i] > 0) begin
        xn_d = x_q[i] + ys;
        yn_d = y_q[i] - xs;
        zn_d = z_q[i] + Atan;
      end else if (y_q[i] < 0) begin
        xn_d = x_q[i] - ys;
        yn_d = y_q[i] + xs;
        zn_d = z_q[i] - Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= xn_d;
        y_q[i+1]    <= yn_d;
        z_q[i+1]    <= zn_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    if (z_q[STEPS] < 0) begin
      ang_d = '0;
    end else if (z_q[STEPS] > HalfPi) begin
      ang_d = tlaik_pkg::HalfPiQ30;
    end else begin
      ang_d = z_q[STEPS][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q      <= ang_d;
      out_side_q <= side_q[STEPS];
    end
  end

  assign valid_o = out_v_q;
  assign angle_o = ang_q;
  assign side_o  = out_side_q;

endmodule

[hdl/tlaik_acos.sv]
// Pipelined arc cosine of a clamped ratio: bit-serial divide, square root, CORDIC.
`timescale 1ns / 1ps
module tlaik_acos #(
  parameter int unsigned STEPS  = tlaik_pkg::CordicSteps,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [tlaik_pkg::NumW-1:0]   num_i,
  input  logic [tlaik_pkg::DenW-1:0]          den_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic [tlaik_pkg::AngW-1:0]          angle_o,
  output logic                                clamp_o,
  output logic [SIDE_W-1:0]                   side_o
);

  localparam int unsigned NW  = tlaik_pkg::NumW;
  localparam int unsigned DW  = tlaik_pkg::DenW;
  localparam int unsigned QB  = tlaik_pkg::QuoBits;
  localparam int unsigned RMW = DW + 1;
  localparam int unsigned CW  = tlaik_pkg::CosW;
  localparam int unsigned RN  = CW;
  localparam int unsigned VW  = 2 * RN;
  localparam int unsigned CRW = 33;

  localparam logic [QB-1:0] OneQ = QB'(tlaik_pkg::OneQ24);
  localparam logic [CW-1:0] OneC = CW'(tlaik_pkg::OneQ24);
  localparam logic [VW-1:0] OneSq = VW'(1) << 48;

  typedef struct packed {
    logic              clamp;
    logic              neg;
    logic [SIDE_W-1:0] side;
  } cside_t;

  // divider
  logic               dv_q    [QB+1];
  logic [RMW-1:0]     drem_q  [QB+1];
  logic [QB-1:0]      dquo_q  [QB+1];
  logic [DW-1:0]      dden_q  [QB+1];
  logic               dpre_q  [QB+1];
  logic               dzero_q [QB+1];
  logic               dneg_q  [QB+1];
  logic [SIDE_W-1:0]  dside_q [QB+1];

  logic [NW-1:0] mag;

  always_comb begin
    mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0]  <= RMW'(mag);
      dquo_q[0]  <= '0;
      dden_q[0]  <= den_i;
      dpre_q[0]  <= (RMW'(mag) >= {den_i, 1'b0}) && !((den_i == '0) && (mag == '0));
      dzero_q[0] <= (den_i == '0) && (mag == '0);
      dneg_q[0]  <= num_i[NW-1];
      dside_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic           ge;
    logic [RMW-1:0] nrem;

    always_comb begin
      ge   = drem_q[j] >= {1'b0, dden_q[j]};
      nrem = ge ? (drem_q[j] - {1'b0, dden_q[j]}) : drem_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j+1]  <= {nrem[RMW-2:0], 1'b0};
        dquo_q[j+1]  <= {dquo_q[j][QB-2:0], ge};
        dden_q[j+1]  <= dden_q[j];
        dpre_q[j+1]  <= dpre_q[j];
        dzero_q[j+1] <= dzero_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dside_q[j+1] <= dside_q[j];
      end
    end
  end

  // clamp
  logic          cv_q;
  logic [CW-1:0] cc_q, cc_d;
  cside_t        cs_q, cs_d;

  always_comb begin
    cc_d       = dquo_q[QB][CW-1:0];
    cs_d.clamp = 1'b0;
    cs_d.side  = dside_q[QB];
    if (dzero_q[QB]) begin
      cc_d = '0;
    end else if (dpre_q[QB] || (dquo_q[QB] > OneQ)) begin
      cc_d       = OneC;
      cs_d.clamp = 1'b1;
    end
    cs_d.neg = dneg_q[QB] && (cc_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else if (en_i) begin
      cv_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= cc_d;
      cs_q <= cs_d;
    end
  end

  // square root of one minus the square
  logic          sv_q    [RN+1];
  logic [VW-1:0] srad_q  [RN+1];
  logic [RN+1:0] srem_q  [RN+1];
  logic [RN-1:0] sroot_q [RN+1];
  logic [CW-1:0] scc_q   [RN+1];
  cside_t        sside_q [RN+1];

  logic [VW-1:0] sq;

  always_comb begin
    sq = cc_q * cc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srad_q[0]  <= OneSq - sq;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      scc_q[0]   <= cc_q;
      sside_q[0] <= cs_q;
    end
  end

  for (genvar j = 0; j < RN; j++) begin : g_sqrt
    logic [RN+1:0] r2, t;
    logic          ge;

    always_comb begin
      r2 = {srem_q[j][RN-1:0], srad_q[j][VW-1-2*j -: 2]};
      t  = {sroot_q[j], 2'b01};
      ge = r2 >= t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srad_q[j+1]  <= srad_q[j];
        srem_q[j+1]  <= ge ? (r2 - t) : r2;
        sroot_q[j+1] <= {sroot_q[j][RN-2:0], ge};
        scc_q[j+1]   <= scc_q[j];
        sside_q[j+1] <= sside_q[j];
      end
    end
  end

  // angle
  logic                       cr_v;
  logic [tlaik_pkg::AngW-1:0] cr_ang;
  cside_t                     cr_side;

  tlaik_cordic #(
    .W      (CRW),
    .STEPS  (STEPS),
    .SIDE_W ($bits(cside_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (sv_q[RN]),
    .px_i    ($signed({2'b00, scc_q[RN], 6'b0})),
    .py_i    ($signed({2'b00, sroot_q[RN], 6'b0})),
    .side_i  (sside_q[RN]),
    .valid_o (cr_v),
    .angle_o (cr_ang),
    .side_o  (cr_side)
  );

  logic                       ov_q;
  logic [tlaik_pkg::AngW-1:0] oang_q;
  logic                       oclamp_q;
  logic [SIDE_W-1:0]          oside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_i) begin
      ov_q <= cr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oang_q   <= cr_side.neg ? (tlaik_pkg::PiQ30 - cr_ang) : cr_ang;
      oclamp_q <= cr_side.clamp;
      oside_q  <= cr_side.side;
    end
  end

  assign valid_o = ov_q;
  assign angle_o = oang_q;
  assign clamp_o = oclamp_q;
  assign side_o  = oside_q;

endmodule
